[rtl/gda_pkg.sv]
// ----------------------------------------------------------------------------
// gda_pkg
// Shared constants, job type and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int OFFSET_BITS = 11;
    localparam int DAY_W       = ((OFFSET_BITS > 6) ? OFFSET_BITS : 6) + 1;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int MDAY_W      = 5;
    localparam int STATUS_W    = 2;
    localparam int YMOD_W      = 9;
    localparam int QDEPTH      = 2;
    localparam int QIDX_W      = $clog2(QDEPTH);

    localparam logic [YEAR_W-1:0]   YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]   YEAR_MAX  = 14'd9999;
    localparam logic [YMOD_W-1:0]   YMOD_LAST = 9'd399;
    localparam logic [MONTH_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_DEC = 4'd12;

    // floor(y / 400) = (y * RECIP_400) >> RECIP_SHIFT for any 14-bit y
    localparam logic [15:0] RECIP_400   = 16'd41944;
    localparam int          RECIP_SHIFT = 24;
    localparam int          PROD_W      = YEAR_W + 16;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic                      bad;
        logic [YEAR_W-1:0]         year;
        logic [YMOD_W-1:0]         ymod;
        logic [MONTH_W-1:0]        month;
        logic signed [DAY_W-1:0]   day;
    } t_job;

    // ymod is year mod 400
    function automatic logic f_is_leap(input logic [YMOD_W-1:0] ymod);
        f_is_leap = (ymod[1:0] == 2'd0) && (ymod != 9'd100) &&
                    (ymod != 9'd200) && (ymod != 9'd300);
    endfunction

    function automatic logic [MDAY_W-1:0] f_month_len(input logic leap,
                                                      input logic [MONTH_W-1:0] m);
        case (m) inside
            MONTH_FEB:               f_month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: f_month_len = 5'd30;
            default:                 f_month_len = 5'd31;
        endcase
    endfunction

endpackage

[rtl/gda_front.sv]
// ----------------------------------------------------------------------------
// gda_front
// Accepts a date beat, reduces the year mod 400, checks the date and
// forms the starting day sum for the walker.
// ----------------------------------------------------------------------------
module gda_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gda_pkg::YEAR_W-1:0]          i_year,
    input  logic [gda_pkg::MONTH_W-1:0]         i_month,
    input  logic [gda_pkg::MDAY_W-1:0]          i_day,
    input  logic signed [gda_pkg::OFFSET_BITS-1:0] i_offset,
    output logic                                o_push,
    output gda_pkg::t_job                       o_job,
    input  logic                                i_full
);
    import gda_pkg::*;

    logic                          r_vld;
    logic [YEAR_W-1:0]             r_year;
    logic [MONTH_W-1:0]            r_month;
    logic [MDAY_W-1:0]             r_day;
    logic signed [OFFSET_BITS-1:0] r_offset;
    logic [PROD_W-1:0]             r_prod;

    logic                          take;
    logic [5:0]                    quot;
    logic [YEAR_W-1:0]             rem;
    logic                          leap;
    logic [MDAY_W-1:0]             mlen;
    logic                          ok;

    assign o_push  = r_vld && !i_full;
    assign o_stall = r_vld && i_full;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_year   <= i_year;
            r_month  <= i_month;
            r_day    <= i_day;
            r_offset <= i_offset;
            r_prod   <= {16'd0, i_year} * {{YEAR_W{1'b0}}, RECIP_400};
        end
    end

    always_comb begin
        quot = r_prod[RECIP_SHIFT +: 6];
        rem  = r_year - ({{(YEAR_W-6){1'b0}}, quot} * 14'd400);
        leap = f_is_leap(rem[YMOD_W-1:0]);
        mlen = f_month_len(leap, r_month);
        ok   = (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX) &&
               (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC) &&
               (r_day != 5'd0) && (r_day <= mlen);
        o_job.bad   = !ok;
        o_job.year  = r_year;
        o_job.ymod  = rem[YMOD_W-1:0];
        o_job.month = r_month;
        o_job.day   = $signed({{(DAY_W-MDAY_W){1'b0}}, r_day}) +
                      $signed({{(DAY_W-OFFSET_BITS){r_offset[OFFSET_BITS-1]}}, r_offset});
    end

endmodule

[rtl/gda_queue.sv]
// ----------------------------------------------------------------------------
// gda_queue
// Short job queue between the checking front and the month walker.
// ----------------------------------------------------------------------------
module gda_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gda_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output gda_pkg::t_job o_job,
    output logic          o_empty
);
    import gda_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr;
    logic [QIDX_W-1:0] r_rd;
    logic [QIDX_W:0]   r_cnt;

    assign o_full  = (r_cnt == QDEPTH[QIDX_W:0]);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[rtl/gda_back.sv]
// ----------------------------------------------------------------------------
// gda_back
// Month walker: moves one month per cycle until the day fits, then
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module gda_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gda_pkg::t_job                 i_job,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gda_pkg::YEAR_W-1:0]    o_year,
    output logic [gda_pkg::MONTH_W-1:0]   o_month,
    output logic [gda_pkg::MDAY_W-1:0]    o_day,
    output logic [gda_pkg::STATUS_W-1:0]  o_status
);
    import gda_pkg::*;

    logic                 r_busy;
    t_job                 r_job;
    logic                 r_o_vld;
    logic [YEAR_W-1:0]    r_o_year;
    logic [MONTH_W-1:0]   r_o_month;
    logic [MDAY_W-1:0]    r_o_day;
    logic [STATUS_W-1:0]  r_o_status;

    t_job                 n_job;
    logic                 done;
    logic [STATUS_W-1:0]  fin_status;
    logic                 leap;
    logic [MDAY_W-1:0]    cur_len;
    logic [MDAY_W-1:0]    prev_len;
    logic signed [DAY_W-1:0] cur_len_s;
    logic                 out_free;
    logic                 finish;

    assign out_free = !r_o_vld || !i_stall;
    assign o_pop    = !r_busy && !i_empty;
    assign finish   = r_busy && done && out_free;

    always_comb begin
        leap      = f_is_leap(r_job.ymod);
        cur_len   = f_month_len(leap, r_job.month);
        prev_len  = (r_job.month == MONTH_JAN) ? 5'd31 :
                    f_month_len(leap, r_job.month - 1'b1);
        cur_len_s = $signed({{(DAY_W-MDAY_W){1'b0}}, cur_len});
        n_job      = r_job;
        done       = 1'b0;
        fin_status = ST_OK;
        if (r_job.bad) begin
            done       = 1'b1;
            fin_status = ST_BAD_DATE;
        end else if (r_job.day > cur_len_s) begin
            n_job.day = r_job.day - cur_len_s;
            if (r_job.month == MONTH_DEC) begin
                if (r_job.year == YEAR_MAX) begin
                    done       = 1'b1;
                    fin_status = ST_RANGE;
                end
                n_job.month = MONTH_JAN;
                n_job.year  = r_job.year + 1'b1;
                n_job.ymod  = (r_job.ymod == YMOD_LAST) ? '0 : r_job.ymod + 1'b1;
            end else begin
                n_job.month = r_job.month + 1'b1;
            end
        end else if (r_job.day < $signed({{(DAY_W-1){1'b0}}, 1'b1})) begin
            n_job.day = r_job.day + $signed({{(DAY_W-MDAY_W){1'b0}}, prev_len});
            if (r_job.month == MONTH_JAN) begin
                if (r_job.year == YEAR_MIN) begin
                    done       = 1'b1;
                    fin_status = ST_RANGE;
                end
                n_job.month = MONTH_DEC;
                n_job.year  = r_job.year - 1'b1;
                n_job.ymod  = (r_job.ymod == '0) ? YMOD_LAST : r_job.ymod - 1'b1;
            end else begin
                n_job.month = r_job.month - 1'b1;
            end
        end else begin
            done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end else if (r_busy && !done) begin
            r_job <= n_job;
        end
        if (finish) begin
            r_o_status <= fin_status;
            if (fin_status == ST_OK) begin
                r_o_year  <= r_job.year;
                r_o_month <= r_job.month;
                r_o_day   <= r_job.day[MDAY_W-1:0];
            end else begin
                r_o_year  <= '0;
                r_o_month <= '0;
                r_o_day   <= '0;
            end
        end
    end

    assign o_valid  = r_o_vld;
    assign o_year   = r_o_year;
    assign o_month  = r_o_month;
    assign o_day    = r_o_day;
    assign o_status = r_o_status;

endmodule

[rtl/gregorian_date_adder.sv]
// ----------------------------------------------------------------------------
// gregorian_date_adder
// Adds a signed day offset to a Gregorian date, one result beat per date.
//
// Input channel: i_in_valid / o_in_stall with year, month, day and offset.
// Output channel: o_out_valid / i_out_stall with the new date and status
// (0 ok, 1 invalid start date, 2 result year out of range; fields 0 when
// status is not ok). A beat moves when valid is high and stall is low.
// Path: the front registers the beat (year mod 400 by reciprocal multiply
// and date check), the queue holds it, the walker steps one month per
// cycle for each month crossed and then finishes into the output register.
// The walker takes the next date only after the last one is finished,
// so dates that cross many months slow the flow. The front keeps
// accepting into a two-entry queue.
// A stalled output beat holds; the walker then waits and the queue and
// front fill, raising o_in_stall. Synchronous active-low reset empties
// the front, queue and walker and drops o_out_valid.
// ----------------------------------------------------------------------------
module gregorian_date_adder (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [gda_pkg::YEAR_W-1:0]              i_start_year,
    input  logic [gda_pkg::MONTH_W-1:0]             i_start_month,
    input  logic [gda_pkg::MDAY_W-1:0]              i_start_day,
    input  logic signed [gda_pkg::OFFSET_BITS-1:0]  i_day_offset,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [gda_pkg::YEAR_W-1:0]              o_result_year,
    output logic [gda_pkg::MONTH_W-1:0]             o_result_month,
    output logic [gda_pkg::MDAY_W-1:0]              o_result_day,
    output logic [gda_pkg::STATUS_W-1:0]            o_status
);
    import gda_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job front_job;
    t_job queue_job;

    gda_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_year   (i_start_year),
        .i_month  (i_start_month),
        .i_day    (i_start_day),
        .i_offset (i_day_offset),
        .o_push   (push),
        .o_job    (front_job),
        .i_full   (full)
    );

    gda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty)
    );

    gda_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (queue_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_year   (o_result_year),
        .o_month  (o_result_month),
        .o_day    (o_result_day),
        .o_status (o_status)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full && !pop))
        else $error("job queue written while full");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |->
        (o_result_month >= MONTH_JAN && o_result_month <= MONTH_DEC &&
         o_result_day != 5'd0 && o_result_year >= YEAR_MIN &&
         o_result_year <= YEAR_MAX))
        else $error("ok result outside calendar range");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        (o_result_year == '0 && o_result_month == '0 && o_result_day == '0))
        else $error("error result with non-zero date fields");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gregorian_date_adder. A short table of dates
// (leap rules, month ends, bad fields, year limits) runs first, then
// random dates and offsets. Both channels idle at random, and the output
// is held off once for a long stretch. Each result beat is compared with
// the result typed into the table or with a behavioural calendar walk.
// ----------------------------------------------------------------------------
module testbench;
    import gda_pkg::*;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 800;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [MDAY_W-1:0]   day;
        logic [STATUS_W-1:0] status;
    } t_date_out;

    typedef struct packed {
        logic [YEAR_W-1:0]             year;
        logic [MONTH_W-1:0]            month;
        logic [MDAY_W-1:0]             day;
        logic signed [OFFSET_BITS-1:0] offset;
        logic                          fixed;
        t_date_out                     want;
    } t_date_job;

    localparam t_date_out NONE      = '0;
    localparam t_date_out BAD       = '{14'd0, 4'd0, 5'd0, ST_BAD_DATE};
    localparam t_date_out OUT_RANGE = '{14'd0, 4'd0, 5'd0, ST_RANGE};

    // year, month, day, offset, result typed in, result
    localparam t_date_job DIRECTED [N_DIRECTED] = '{
        '{14'd2024,  4'd2,  5'd29, 11'sd0,  1'b1, '{14'd2024, 4'd2, 5'd29, ST_OK}},
        '{14'd2000,  4'd2,  5'd29, 11'sd0,  1'b1, '{14'd2000, 4'd2, 5'd29, ST_OK}},
        '{14'd2023,  4'd2,  5'd29, 11'sd0,  1'b1, BAD},
        '{14'd1900,  4'd2,  5'd29, 11'sd0,  1'b1, BAD},
        '{14'd2023,  4'd4,  5'd31, 11'sd0,  1'b1, BAD},
        '{14'd2023,  4'd6,  5'd30, 11'sd0,  1'b1, '{14'd2023, 4'd6, 5'd30, ST_OK}},
        '{14'd0,     4'd1,  5'd1,  11'sd0,  1'b1, BAD},
        '{14'd10000, 4'd1,  5'd1,  11'sd0,  1'b1, BAD},
        '{14'd16383, 4'd12, 5'd31, -11'sd1, 1'b1, BAD},
        '{14'd2023,  4'd0,  5'd1,  11'sd5,  1'b1, BAD},
        '{14'd2023,  4'd13, 5'd1,  11'sd0,  1'b1, BAD},
        '{14'd2023,  4'd15, 5'd31, 11'h3FF, 1'b1, BAD},
        '{14'd2023,  4'd1,  5'd0,  11'sd0,  1'b1, BAD},
        '{14'd9999,  4'd12, 5'd31, 11'sd0,  1'b1, '{14'd9999, 4'd12, 5'd31, ST_OK}},
        '{14'd1,     4'd1,  5'd1,  11'sd0,  1'b1, '{14'd1, 4'd1, 5'd1, ST_OK}},
        '{14'd9999,  4'd12, 5'd31, 11'sd1,  1'b1, OUT_RANGE},
        '{14'd1,     4'd1,  5'd1,  -11'sd1, 1'b1, OUT_RANGE},
        '{14'd9999,  4'd12, 5'd31, 11'h400, 1'b0, NONE},
        '{14'd1,     4'd1,  5'd1,  11'h3FF, 1'b0, NONE},
        '{14'd9999,  4'd10, 5'd1,  11'h3FF, 1'b0, NONE},
        '{14'd1,     4'd3,  5'd1,  11'h400, 1'b0, NONE},
        '{14'd2023,  4'd8,  5'd1,  -11'sd1, 1'b0, NONE},
        '{14'd2024,  4'd3,  5'd1,  -11'sd1, 1'b0, NONE},
        '{14'd2023,  4'd12, 5'd31, 11'sd1,  1'b0, NONE},
        '{14'd2023,  4'd1,  5'd31, 11'sd1,  1'b0, NONE}
    };

    logic                          i_clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [YEAR_W-1:0]             start_year = '0;
    logic [MONTH_W-1:0]            start_month = '0;
    logic [MDAY_W-1:0]             start_day = '0;
    logic signed [OFFSET_BITS-1:0] day_offset = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [YEAR_W-1:0]             result_year;
    logic [MONTH_W-1:0]            result_month;
    logic [MDAY_W-1:0]             result_day;
    logic [STATUS_W-1:0]           status;

    t_date_job jobs[$];
    t_date_job on_wire;
    t_date_out pending_dates[$];
    t_date_out seen_date;
    t_date_out due_date;
    int        next_job = 0;
    int        beats_out = 0;
    int        mismatches = 0;
    int        hold_left = 0;
    logic      hold_done = 1'b0;
    logic      hold_active;
    int        cycles = 0;

    gregorian_date_adder dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_year   (start_year),
        .i_start_month  (start_month),
        .i_start_day    (start_day),
        .i_day_offset   (day_offset),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_year  (result_year),
        .o_result_month (result_month),
        .o_result_day   (result_day),
        .o_status       (status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(input int y, input int m);
        case (m)
            int'(MONTH_FEB): return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:     return 30;
            default:         return 31;
        endcase
    endfunction

    // walks the date a month at a time, as the block does
    function automatic t_date_out shift_date(input logic [YEAR_W-1:0] y_in,
                                             input logic [MONTH_W-1:0] m_in,
                                             input logic [MDAY_W-1:0] d_in,
                                             input logic signed [OFFSET_BITS-1:0] off);
        int        y;
        int        m;
        int        d;
        t_date_out r;
        y = int'(y_in);
        m = int'(m_in);
        d = int'(d_in);
        r = NONE;
        if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || m < int'(MONTH_JAN) ||
            m > int'(MONTH_DEC) || d < 1 || d > days_in_month(y, m)) begin
            r.status = ST_BAD_DATE;
            return r;
        end
        d = d + int'(off);
        r.status = ST_OK;
        while (r.status == ST_OK && d > days_in_month(y, m)) begin
            d -= days_in_month(y, m);
            m++;
            if (m > int'(MONTH_DEC)) begin
                m = int'(MONTH_JAN);
                y++;
                if (y > int'(YEAR_MAX))
                    r.status = ST_RANGE;
            end
        end
        while (r.status == ST_OK && d < 1) begin
            m--;
            if (m < int'(MONTH_JAN)) begin
                m = int'(MONTH_DEC);
                y--;
                if (y < int'(YEAR_MIN)) begin
                    r.status = ST_RANGE;
                    break;
                end
            end
            d += days_in_month(y, m);
        end
        if (r.status == ST_OK) begin
            r.year  = YEAR_W'(y);
            r.month = MONTH_W'(m);
            r.day   = MDAY_W'(d);
        end
        return r;
    endfunction

    // mostly valid dates near the awkward spots, some bad fields, some noise
    function automatic t_date_job random_job();
        t_date_job j;
        int        pick;
        int        y;
        int        m;
        int        len;
        j = '0;
        pick = $urandom_range(99);
        if (pick < 15) begin
            j.year   = YEAR_W'($urandom);
            j.month  = MONTH_W'($urandom);
            j.day    = MDAY_W'($urandom);
            j.offset = OFFSET_BITS'($urandom);
            return j;
        end
        case ($urandom_range(3))
            0:       y = $urandom_range(3, 1);
            1:       y = $urandom_range(9999, 9996);
            2:       y = 100 * $urandom_range(99, 1);
            default: y = $urandom_range(9999, 1);
        endcase
        m = $urandom_range(12, 1);
        len = days_in_month(y, m);
        j.year  = YEAR_W'(y);
        j.month = MONTH_W'(m);
        if (pick < 22) begin
            j.day = MDAY_W'((len == 31 || $urandom_range(1) == 0) ? 0
                                                                   : $urandom_range(31, len + 1));
        end else if (pick < 27) begin
            j.month = MONTH_W'(($urandom_range(1) == 0) ? 0 : $urandom_range(15, 13));
            j.day   = MDAY_W'($urandom_range(31, 1));
        end else begin
            j.day = MDAY_W'(($urandom_range(1) == 0) ? $urandom_range(len, len - 2)
                                                      : $urandom_range(len, 1));
        end
        if ($urandom_range(2) == 0)
            j.offset = OFFSET_BITS'($urandom_range(80) - 40);
        else
            j.offset = OFFSET_BITS'($urandom);
        return j;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                pending_dates.push_back(on_wire.fixed ? on_wire.want :
                    shift_date(on_wire.year, on_wire.month, on_wire.day, on_wire.offset));
            end
            if (!in_valid || !in_stall) begin
                if (next_job < jobs.size() &&
                    ((next_job >= 300 && next_job < 450) || $urandom_range(99) >= 36)) begin
                    on_wire = jobs[next_job];
                    next_job++;
                    in_valid    <= 1'b1;
                    start_year  <= on_wire.year;
                    start_month <= on_wire.month;
                    start_day   <= on_wire.day;
                    day_offset  <= on_wire.offset;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off so the block backs up to its input
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && beats_out >= 120) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    assign hold_active = (hold_left != 0);

    // receiver and checker
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                seen_date = '{result_year, result_month, result_day, status};
                beats_out <= beats_out + 1;
                if (pending_dates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: %0d-%0d-%0d status %0d", seen_date.year,
                                 seen_date.month, seen_date.day, seen_date.status);
                end else begin
                    due_date = pending_dates.pop_front();
                    if (seen_date !== due_date) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: want %0d-%0d-%0d st %0d, got %0d-%0d-%0d st %0d",
                                     beats_out, due_date.year, due_date.month, due_date.day,
                                     due_date.status, seen_date.year, seen_date.month,
                                     seen_date.day, seen_date.status);
                    end
                end
            end
            out_stall <= hold_active ||
                         (!(beats_out >= 300 && beats_out < 450) && $urandom_range(99) < 36);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < N_DIRECTED; i++)
            jobs.push_back(DIRECTED[i]);
        for (int i = 0; i < N_RANDOM; i++)
            jobs.push_back(random_job());
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        while (next_job < jobs.size() || in_valid || pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
